/* rtl/core/gb5_pkg.sv */
`timescale 1ns / 1ps

package gb5_pkg;

   // pixel and coordinate widths
   localparam int PIX_W  = 16;
   localparam int COL_W  = 12;
   localparam int ROW_W  = 16;
   localparam int FW_W   = 13;
   localparam int CSR_W  = 16;
   localparam int VSUM_W = 20;
   localparam int HSUM_W = 24;
   localparam int CW     = 19;
   localparam int NSLOT  = 4;
   localparam int NTAP   = 5;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef pix_type [NTAP-1:0]       column_type;
   typedef pix_type [NSLOT-1:0]      slots_type;
   typedef logic [2:0]               idx_type;
   typedef idx_type [NTAP-1:0]       idx_set_type;
   typedef logic [VSUM_W-1:0]        vsum_type;
   typedef vsum_type [NTAP-1:0]      vsum_set_type;
   typedef logic signed [CW-1:0]     coord_type;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // result tag travelling with the column sums
   typedef struct packed {
      idx_set_type         wj;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic                last;
      logic                eof;
   } tag_type;

endpackage

/* rtl/core/gb5_line_buf.sv */
`timescale 1ns / 1ps

module gb5_line_buf #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                         clock,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output gb5_pkg::slots_type           rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  gb5_pkg::slots_type           wr_data
);

   gb5_pkg::slots_type mem [MAX_WIDTH];

   // four stored rows per column, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/gb5_cell.sv */
`timescale 1ns / 1ps

module gb5_cell (
   input  logic                     clock,
   input  logic                     shift_en,
   input  gb5_pkg::column_type      col_in,
   input  gb5_pkg::idx_set_type     wi,
   output gb5_pkg::column_type      col_out,
   output gb5_pkg::vsum_type        vsum
);

   gb5_pkg::column_type col_ff;
   gb5_pkg::vsum_type   p0, p1, p2, p3, p4;

   // one window column, taken from the right-hand neighbour on each transfer
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // vertical 1 4 6 4 1 sum over the clamped rows
   always_comb begin
      p0 = gb5_pkg::VSUM_W'(col_ff[wi[0]]);
      p1 = gb5_pkg::VSUM_W'(col_ff[wi[1]]);
      p2 = gb5_pkg::VSUM_W'(col_ff[wi[2]]);
      p3 = gb5_pkg::VSUM_W'(col_ff[wi[3]]);
      p4 = gb5_pkg::VSUM_W'(col_ff[wi[4]]);
      vsum = p0 + (p1 << 2) + (p2 << 2) + (p2 << 1) + (p3 << 2) + p4;
   end

endmodule

/* rtl/core/gb5_kernel.sv */
`timescale 1ns / 1ps

module gb5_kernel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue_valid,
   output logic                          issue_ready,
   input  gb5_pkg::vsum_set_type         col_sums,
   input  gb5_pkg::tag_type              issue_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gb5_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [gb5_pkg::COL_W-1:0]     rsp_out_col,
   output logic [gb5_pkg::ROW_W-1:0]     rsp_out_row,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_frame
);

   logic                    s1_v_ff, s1_v_in;
   gb5_pkg::vsum_set_type   s1_sum_ff;
   gb5_pkg::tag_type        s1_tag_ff;
   logic                    out_v_ff, out_v_in;
   logic                    out_en;
   logic [gb5_pkg::HSUM_W-1:0] hsum, hround;
   logic [gb5_pkg::HSUM_W-1:0] h0, h1, h2, h3, h4;

   assign out_en      = !out_v_ff || rsp_ready;
   assign issue_ready = !s1_v_ff || out_en;
   assign s1_v_in     = issue_ready ? issue_valid : s1_v_ff;
   assign out_v_in    = out_en ? s1_v_ff : out_v_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // pick the clamped columns out of the cell sums
   always_ff @(posedge clock) begin
      if (issue_ready) begin
         for (int j = 0; j < gb5_pkg::NTAP; j++) begin
            s1_sum_ff[j] <= col_sums[issue_tag.wj[j]];
         end
         s1_tag_ff <= issue_tag;
      end
   end

   // horizontal 1 4 6 4 1 sum, rounded to nearest
   always_comb begin
      h0 = gb5_pkg::HSUM_W'(s1_sum_ff[0]);
      h1 = gb5_pkg::HSUM_W'(s1_sum_ff[1]);
      h2 = gb5_pkg::HSUM_W'(s1_sum_ff[2]);
      h3 = gb5_pkg::HSUM_W'(s1_sum_ff[3]);
      h4 = gb5_pkg::HSUM_W'(s1_sum_ff[4]);
      hsum   = h0 + (h1 << 2) + (h2 << 2) + (h2 << 1) + (h3 << 2) + h4;
      hround = hsum + gb5_pkg::HSUM_W'(128);
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_en && s1_v_ff) begin
         rsp_pixel_out    <= hround[gb5_pkg::HSUM_W-1:8];
         rsp_out_col      <= s1_tag_ff.col;
         rsp_out_row      <= s1_tag_ff.row;
         rsp_last_of_run  <= s1_tag_ff.last;
         rsp_end_of_frame <= s1_tag_ff.eof;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule

/* rtl/core/gaussian_blur_5x5_clamp_edge.sv */
`timescale 1ns / 1ps
// 5x5 binomial blur over a raster pixel stream, edges clamped.
// Each result passes the single result generator, the column-select register and the
// output register. Throughput: one pixel per cycle while rsp_ready is high; a pixel
// causing n results (3 at a row end, up to 9 at frame end) holds input until all issue.
// Reset (synchronous) clears position, control and sizes to 4096x4096; the line
// buffer and window are not cleared and need no clearing pass.

module gaussian_blur_5x5_clamp_edge #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gb5_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gb5_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [gb5_pkg::COL_W-1:0]     rsp_out_col,
   output logic [gb5_pkg::ROW_W-1:0]     rsp_out_row,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_frame,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [gb5_pkg::CSR_W-1:0]     csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam gb5_pkg::coord_type MAX_W_C = gb5_pkg::coord_type'(MAX_WIDTH);
   localparam gb5_pkg::coord_type ZERO_C  = gb5_pkg::coord_type'(0);
   localparam gb5_pkg::coord_type ONE_C   = gb5_pkg::coord_type'(1);
   localparam gb5_pkg::coord_type TWO_C   = gb5_pkg::coord_type'(2);
   localparam gb5_pkg::coord_type THREE_C = gb5_pkg::coord_type'(3);
   localparam gb5_pkg::coord_type FOUR_C  = gb5_pkg::coord_type'(4);

   function automatic gb5_pkg::coord_type clamp_c(input gb5_pkg::coord_type v,
                                                  input gb5_pkg::coord_type lo,
                                                  input gb5_pkg::coord_type hi);
      gb5_pkg::coord_type res;
      res = v;
      if (v < lo) res = lo;
      else if (v > hi) res = hi;
      return res;
   endfunction

   // configuration and position
   logic [gb5_pkg::FW_W-1:0]  frame_width_ff;
   logic [gb5_pkg::ROW_W-1:0] frame_height_ff;
   logic [gb5_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [gb5_pkg::ROW_W-1:0] in_row_ff, in_row_in;

   // result generator
   logic               job_v_ff, job_v_in;
   gb5_pkg::coord_type x_ff, y_ff, xlo_ff, xhi_ff, yhi_ff;
   gb5_pkg::coord_type c_ff, r_ff, w_ff, h_ff;

   gb5_pkg::coord_type c_s, r_s, w_s, h_s, w_raw, h_raw;
   gb5_pkg::coord_type xlo, xhi, ylo, yhi;
   logic               has_results, accept, issue, issue_last, issue_ready, in_range;

   gb5_pkg::slots_type    rd_data, wr_slots;
   gb5_pkg::column_type   new_col;
   gb5_pkg::column_type   chain [gb5_pkg::NTAP];
   gb5_pkg::vsum_set_type col_sums;
   gb5_pkg::idx_set_type  wi, wj;
   gb5_pkg::tag_type      tag;
   logic [AW-1:0]         rd_addr;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= gb5_pkg::FW_W'(4096);
         frame_height_ff <= gb5_pkg::ROW_W'(4096);
      end else if (csr_valid) begin
         case (gb5_pkg::csr_index_type'(csr_index))
            gb5_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[gb5_pkg::FW_W-1:0];
            end
            gb5_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // frame sizes in use and the span of results for this pixel
   always_comb begin
      c_s   = gb5_pkg::coord_type'(in_col_ff);
      r_s   = gb5_pkg::coord_type'(in_row_ff);
      w_raw = gb5_pkg::coord_type'(frame_width_ff);
      h_raw = gb5_pkg::coord_type'(frame_height_ff);
      w_s   = (w_raw < THREE_C) ? THREE_C :
              ((w_raw > MAX_W_C) ? MAX_W_C : w_raw);
      h_s   = (h_raw < THREE_C) ? THREE_C : h_raw;
      ylo   = (r_s < TWO_C) ? ZERO_C : r_s - TWO_C;
      yhi   = (r_s >= h_s - ONE_C) ? h_s - ONE_C : r_s - TWO_C;
      xlo   = (c_s < TWO_C) ? ZERO_C : c_s - TWO_C;
      xhi   = (c_s >= w_s - ONE_C) ? w_s - ONE_C : c_s - TWO_C;
      has_results = (ylo <= yhi) && (xlo <= xhi);
   end

   // handshake
   assign issue_last = (x_ff == xhi_ff) && (y_ff == yhi_ff);
   assign issue      = job_v_ff && issue_ready;
   assign req_ready  = !job_v_ff || (issue && issue_last);
   assign accept     = req_valid && req_ready;

   // next input position
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (accept) begin
         if (c_s >= w_s - ONE_C) begin
            in_col_in = '0;
            in_row_in = (r_s >= h_s - ONE_C) ? '0 : in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
      end
   end

   // generator control
   always_comb begin
      job_v_in = job_v_ff;
      if (issue && issue_last) job_v_in = 1'b0;
      if (accept) job_v_in = has_results;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_v_ff <= 1'b0;
      end else begin
         job_v_ff <= job_v_in;
      end
   end

   // generator payload: load a new span or step along the row, then to the next row
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= xlo;
         y_ff   <= ylo;
         xlo_ff <= xlo;
         xhi_ff <= xhi;
         yhi_ff <= yhi;
         c_ff   <= c_s;
         r_ff   <= r_s;
         w_ff   <= w_s;
         h_ff   <= h_s;
      end else if (issue && !issue_last) begin
         if (x_ff == xhi_ff) begin
            x_ff <= xlo_ff;
            y_ff <= y_ff + ONE_C;
         end else begin
            x_ff <= x_ff + ONE_C;
         end
      end
   end

   // clamped window indexes for the result being issued
   always_comb begin
      for (int i = 0; i < gb5_pkg::NTAP; i++) begin
         wi[i] = 3'(clamp_c(clamp_c(y_ff + gb5_pkg::coord_type'(i) - TWO_C, ZERO_C,
                                    h_ff - ONE_C) - (r_ff - FOUR_C), ZERO_C, FOUR_C));
         wj[i] = 3'(clamp_c(clamp_c(x_ff + gb5_pkg::coord_type'(i) - TWO_C, ZERO_C,
                                    w_ff - ONE_C) - (c_ff - FOUR_C), ZERO_C, FOUR_C));
      end
      tag.wj   = wj;
      tag.col  = x_ff[gb5_pkg::COL_W-1:0];
      tag.row  = y_ff[gb5_pkg::ROW_W-1:0];
      tag.last = issue_last;
      tag.eof  = (x_ff == w_ff - ONE_C) && (y_ff == h_ff - ONE_C);
   end

   // line buffer: read ahead at the next column, shift the column on transfer
   assign in_range = (32'(in_col_ff) < MAX_WIDTH);
   assign rd_addr  = AW'(in_col_in);
   assign wr_slots = {rd_data[2], rd_data[1], rd_data[0], req_pixel_in};

   gb5_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (accept && in_range),
      .wr_addr (AW'(in_col_ff)),
      .wr_data (wr_slots)
   );

   // new window column, oldest row first
   always_comb begin
      new_col[4] = req_pixel_in;
      for (int i = 0; i < gb5_pkg::NSLOT; i++) begin
         new_col[3 - i] = in_range ? rd_data[i] : '0;
      end
   end

   // chain of window cells
   for (genvar j = 0; j < gb5_pkg::NTAP; j++) begin : g_cell
      gb5_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .col_in   ((j == gb5_pkg::NTAP - 1) ? new_col : chain[(j + 1) % gb5_pkg::NTAP]),
         .wi       (wi),
         .col_out  (chain[j]),
         .vsum     (col_sums[j])
      );
   end

   gb5_kernel u_kernel (
      .clock            (clock),
      .reset            (reset),
      .issue_valid      (job_v_ff),
      .issue_ready      (issue_ready),
      .col_sums         (col_sums),
      .issue_tag        (tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_row      (rsp_out_row),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
